/* sv/bcmscan_pkg.sv */
package bcmscan_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register widths
  localparam int BASE_W     = 24;
  localparam int BRIGHT_W   = 8;
  localparam int PLANES_W   = 3;
  localparam int ROWS_W     = 6;
  localparam int OVH_W      = 16;
  localparam int ROWLEN_W   = 13;

  // result field widths
  localparam int MAIN_W     = 26;
  localparam int OEPER_W    = 27;
  localparam int OECMP_W    = 26;
  localparam int MUXROW_W   = 5;
  localparam int PLANEIDX_W = 2;
  localparam int ROWIDX_W   = 5;
  localparam int OFFS_W     = 17;

  // register reset values
  localparam int BASE_RST        = 1000;
  localparam int BRIGHT_RST      = 200;
  localparam int PLANE_COUNT_RST = 4;
  localparam int ROW_COUNT_RST   = 16;
  localparam int OVH_RST         = 0;
  localparam int ROWLEN_RST      = 64;

  // defaults for the top level parameters
  localparam int DEF_MAX_ROWS    = 32;
  localparam int DEF_MAX_PLANES  = 4;
  localparam int DEF_QUEUE_DEPTH = 2;

  // brightness scale is 2^8 - 1, so the divide folds base-256 digits
  localparam int DIV_RADIX_W = 8;
  localparam int BRIGHT_FULL = (1 << DIV_RADIX_W) - 1;
  localparam int OVH_SCALE   = 10;
  localparam int ROW_LEN_MAX = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_CYCLE    = 3'd0,
    REG_BRIGHTNESS    = 3'd1,
    REG_PLANE_COUNT   = 3'd2,
    REG_ROW_COUNT     = 3'd3,
    REG_TICK_OVERHEAD = 3'd4,
    REG_ROW_LENGTH    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [BASE_W-1:0]   base_cycle_length;
    logic [BRIGHT_W-1:0] brightness_level;
    logic [PLANES_W-1:0] plane_count;
    logic [ROWS_W-1:0]   row_count;
    logic [OVH_W-1:0]    tick_overhead;
    logic [ROWLEN_W-1:0] row_length;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // result fields that are settled before the on-time divide
  typedef struct packed {
    logic [MAIN_W-1:0]     main_period;
    logic [OEPER_W-1:0]    oe_period;
    logic                  mux_update;
    logic [MUXROW_W-1:0]   mux_row;
    logic [PLANEIDX_W-1:0] plane_index;
    logic [ROWIDX_W-1:0]   row_index;
    logic                  front_buffer;
    logic [OFFS_W-1:0]     row_offset;
  } res_tail_t;

endpackage

/* sv/bcmscan_if.sv */
interface bcmscan_tick_if;
  logic valid;
  logic ready;
  logic swap_request;

  modport source (output valid, output swap_request, input ready);
  modport sink (input valid, input swap_request, output ready);
endinterface

interface bcmscan_result_if;
  import bcmscan_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MAIN_W-1:0]     main_period;
  logic [OEPER_W-1:0]    oe_period;
  logic [OECMP_W-1:0]    oe_compare;
  logic                  mux_update;
  logic [MUXROW_W-1:0]   mux_row;
  logic [PLANEIDX_W-1:0] plane_index;
  logic [ROWIDX_W-1:0]   row_index;
  logic                  front_buffer;
  logic [OFFS_W-1:0]     row_offset;

  modport source (output valid, output main_period, output oe_period, output oe_compare,
                  output mux_update, output mux_row, output plane_index, output row_index,
                  output front_buffer, output row_offset, input ready);
  modport sink (input valid, input main_period, input oe_period, input oe_compare,
                input mux_update, input mux_row, input plane_index, input row_index,
                input front_buffer, input row_offset, output ready);
endinterface

/* sv/bcmscan_front.sv */
module bcmscan_front #(
  parameter int MAX_ROWS   = bcmscan_pkg::DEF_MAX_ROWS,
  parameter int MAX_PLANES = bcmscan_pkg::DEF_MAX_PLANES,
  parameter int EW         = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bcmscan_pkg::cfg_t      cfg,
  input  bcmscan_pkg::q_status_t qstat,
  bcmscan_tick_if.sink           tick,
  output logic                   push,
  output logic [EW-1:0]          entry
);
  import bcmscan_pkg::*;

  localparam int PCW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int RCW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam int NP_RAW = (PLANE_COUNT_RST == 0) ? 1 :
                          (PLANE_COUNT_RST == 3) ? 4 : PLANE_COUNT_RST;
  localparam int NP_RST = (NP_RAW > MAX_PLANES) ? MAX_PLANES : NP_RAW;
  localparam int NR_RAW = (ROW_COUNT_RST == 0) ? 1 : ROW_COUNT_RST;
  localparam int NR_RST = (NR_RAW > MAX_ROWS) ? MAX_ROWS : NR_RAW;

  logic [PCW-1:0] plane_counter, plane_counter_next;
  logic [RCW-1:0] row_counter, row_counter_next;
  logic           swap_pending, swap_pending_next;
  logic           back_select, back_select_next;

  logic [PLANES_W-1:0] p_raw;
  logic [ROWS_W-1:0]   r_raw;
  logic [PCW:0]        np;
  logic [RCW:0]        nr;
  logic [PCW:0]        pc_inc;
  logic [RCW:0]        rc_inc;
  logic                plane_wrap, row_wrap, sp, swap, halve, upd;
  logic [MUXROW_W-1:0] mux_row;

  assign tick.ready = !qstat.full;
  assign push = tick.valid && tick.ready;

  always_comb begin
    if (cfg.plane_count == '0) begin
      p_raw = PLANES_W'(1);
    end else if (cfg.plane_count == PLANES_W'(3)) begin
      p_raw = PLANES_W'(4);
    end else begin
      p_raw = cfg.plane_count;
    end
    np = (p_raw > MAX_PLANES) ? (PCW+1)'(MAX_PLANES) : (PCW+1)'(p_raw);

    r_raw = (cfg.row_count == '0) ? ROWS_W'(1) : cfg.row_count;
    nr = (r_raw > MAX_ROWS) ? (RCW+1)'(MAX_ROWS) : (RCW+1)'(r_raw);

    // a pending request may be joined by this tick's request
    sp = swap_pending | tick.swap_request;

    pc_inc = (PCW+1)'(plane_counter) + 1'b1;
    rc_inc = (RCW+1)'(row_counter) + 1'b1;
    plane_wrap = (pc_inc >= np);
    row_wrap = plane_wrap && (rc_inc >= nr);

    plane_counter_next = plane_wrap ? '0 : PCW'(pc_inc);
    if (!plane_wrap) begin
      row_counter_next = row_counter;
    end else if (row_wrap) begin
      row_counter_next = '0;
    end else begin
      row_counter_next = RCW'(rc_inc);
    end

    swap = row_wrap && sp;
    back_select_next = back_select ^ swap;
    swap_pending_next = sp && !swap;

    // single plane drives select lines every tick with the old row
    upd = 1'b0;
    mux_row = '0;
    if (np == (PCW+1)'(1)) begin
      upd = 1'b1;
      mux_row = MUXROW_W'(row_counter);
    end else if (!plane_wrap && pc_inc == (PCW+1)'(1)) begin
      upd = 1'b1;
      mux_row = MUXROW_W'(row_counter);
    end

    halve = (plane_counter == '0) && (np != (PCW+1)'(1));

    entry = {plane_counter, halve, upd, mux_row, PLANEIDX_W'(plane_counter_next),
             row_counter_next, ~back_select_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_counter <= PCW'(NP_RST - 1);
      row_counter <= RCW'(NR_RST - 1);
      swap_pending <= 1'b0;
      back_select <= 1'b0;
    end else if (push) begin
      plane_counter <= plane_counter_next;
      row_counter <= row_counter_next;
      swap_pending <= swap_pending_next;
      back_select <= back_select_next;
    end
  end

endmodule

/* sv/bcmscan_fifo.sv */
module bcmscan_fifo #(
  parameter int W     = 16,
  parameter int DEPTH = bcmscan_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [W-1:0]           wdata,
  input  logic                   pop,
  output logic [W-1:0]           rdata,
  output bcmscan_pkg::q_status_t qstat
);
  import bcmscan_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign qstat.empty = (count == '0);
  assign qstat.full = (count == CW'(DEPTH));
  assign do_push = push && !qstat.full;
  assign do_pop = pop && !qstat.empty;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/bcmscan_back.sv */
module bcmscan_back #(
  parameter int MAX_ROWS   = bcmscan_pkg::DEF_MAX_ROWS,
  parameter int MAX_PLANES = bcmscan_pkg::DEF_MAX_PLANES,
  parameter int EW         = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bcmscan_pkg::cfg_t cfg,
  input  logic              q_valid,
  input  logic [EW-1:0]     q_data,
  output logic              q_take,
  bcmscan_result_if.source  result
);
  import bcmscan_pkg::*;

  localparam int PCW     = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int RCW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PSH_MAX = (MAX_PLANES > 1) ? MAX_PLANES - 2 : 0;
  localparam int PERW    = BASE_W + PSH_MAX;
  localparam int PRW     = PERW + BRIGHT_W;
  localparam int OFW     = RCW + ROWLEN_W;

  // entry fields
  logic [PCW-1:0]        e_pc;
  logic                  e_halve, e_upd, e_front;
  logic [MUXROW_W-1:0]   e_mrow;
  logic [PLANEIDX_W-1:0] e_plane;
  logic [RCW-1:0]        e_row;

  assign {e_pc, e_halve, e_upd, e_mrow, e_plane, e_row, e_front} = q_data;

  logic en;
  logic out_valid;

  assign en = !out_valid || result.ready;
  assign q_take = en;

  // stage 1: period, timer reloads, row offset
  logic [PERW-1:0]     period_c, ovh_x;
  logic [PERW-1:0]     main_c;
  logic [PERW:0]       oeper_c;
  logic [ROWLEN_W-1:0] len_c;
  logic [OFW-1:0]      offs_c;
  res_tail_t           tail_c;

  always_comb begin
    if (e_pc == '0) begin
      period_c = PERW'(cfg.base_cycle_length);
    end else begin
      period_c = PERW'(cfg.base_cycle_length) << (e_pc - 1'b1);
    end
    ovh_x = PERW'(cfg.tick_overhead);
    main_c = (period_c > ovh_x) ? period_c - ovh_x : '0;
    oeper_c = (PERW+1)'(period_c) +
              (PERW+1)'(cfg.tick_overhead) * (PERW+1)'(OVH_SCALE);
    len_c = (cfg.row_length > ROWLEN_W'(ROW_LEN_MAX)) ? ROWLEN_W'(ROW_LEN_MAX)
                                                      : cfg.row_length;
    offs_c = OFW'(e_row) * OFW'(len_c);

    tail_c.main_period = MAIN_W'(main_c);
    tail_c.oe_period = OEPER_W'(oeper_c);
    tail_c.mux_update = e_upd;
    tail_c.mux_row = e_mrow;
    tail_c.plane_index = e_plane;
    tail_c.row_index = ROWIDX_W'(e_row);
    tail_c.front_buffer = e_front;
    tail_c.row_offset = OFFS_W'(offs_c);
  end

  logic            v1, v2, v3;
  logic [PERW-1:0] period1;
  logic            halve1, halve2, halve3;
  res_tail_t       tail1, tail2, tail3, tail4;
  logic [PRW-1:0]  prod2;
  logic [PRW-1:0]  q3, y3;
  logic [OECMP_W-1:0] oe_cmp4;

  // x = 255*q + y is kept; each fold moves the high digits of y into q
  logic [PRW-1:0] ya, qa, yb, qb;
  logic [PRW-1:0] yc, qc, yd, qd, qf;

  always_comb begin
    qa = prod2 >> DIV_RADIX_W;
    ya = qa + PRW'(prod2[DIV_RADIX_W-1:0]);
    qb = qa + (ya >> DIV_RADIX_W);
    yb = (ya >> DIV_RADIX_W) + PRW'(ya[DIV_RADIX_W-1:0]);

    qc = q3 + (y3 >> DIV_RADIX_W);
    yc = (y3 >> DIV_RADIX_W) + PRW'(y3[DIV_RADIX_W-1:0]);
    qd = qc + (yc >> DIV_RADIX_W);
    yd = (yc >> DIV_RADIX_W) + PRW'(yc[DIV_RADIX_W-1:0]);
    // residue is now below twice the divisor
    qf = (yd >= PRW'(BRIGHT_FULL)) ? qd + 1'b1 : qd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      period1 <= period_c;
      halve1 <= e_halve;
      tail1 <= tail_c;

      prod2 <= PRW'(period1) * PRW'(cfg.brightness_level);
      halve2 <= halve1;
      tail2 <= tail1;

      q3 <= qb;
      y3 <= yb;
      halve3 <= halve2;
      tail3 <= tail2;

      oe_cmp4 <= OECMP_W'(halve3 ? (qf >> 1) : qf);
      tail4 <= tail3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  assign result.valid = out_valid;
  assign result.main_period = tail4.main_period;
  assign result.oe_period = tail4.oe_period;
  assign result.oe_compare = oe_cmp4;
  assign result.mux_update = tail4.mux_update;
  assign result.mux_row = tail4.mux_row;
  assign result.plane_index = tail4.plane_index;
  assign result.row_index = tail4.row_index;
  assign result.front_buffer = tail4.front_buffer;
  assign result.row_offset = tail4.row_offset;

endmodule

/* sv/bcm_led_panel_scan_sequencer_top.sv */
// throughput: one tick per cycle while the result output is not stalled, set by the
// 4-stage period and on-time pipeline
// a short queue between the counter front end and the pipeline absorbs output stalls
// reset: registers take their defaults, plane and row counters start at the last
// plane and row, swap request and buffer select clear; no clearing pass
module bcm_led_panel_scan_sequencer_top #(
  parameter int MAX_ROWS    = bcmscan_pkg::DEF_MAX_ROWS,
  parameter int MAX_PLANES  = bcmscan_pkg::DEF_MAX_PLANES,
  parameter int QUEUE_DEPTH = bcmscan_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bcmscan_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcmscan_pkg::CFG_DATA_W-1:0] cfg_data,
  bcmscan_tick_if.sink                     tick,
  bcmscan_result_if.source                 result
);
  import bcmscan_pkg::*;

  localparam int PCW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int RCW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int EW  = PCW + RCW + 3 + MUXROW_W + PLANEIDX_W;

  cfg_t      cfg;
  q_status_t qstat;
  logic          push, q_take;
  logic [EW-1:0] entry, q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_cycle_length <= BASE_W'(BASE_RST);
      cfg.brightness_level <= BRIGHT_W'(BRIGHT_RST);
      cfg.plane_count <= PLANES_W'(PLANE_COUNT_RST);
      cfg.row_count <= ROWS_W'(ROW_COUNT_RST);
      cfg.tick_overhead <= OVH_W'(OVH_RST);
      cfg.row_length <= ROWLEN_W'(ROWLEN_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_CYCLE:    cfg.base_cycle_length <= cfg_data[BASE_W-1:0];
        REG_BRIGHTNESS:    cfg.brightness_level <= cfg_data[BRIGHT_W-1:0];
        REG_PLANE_COUNT:   cfg.plane_count <= cfg_data[PLANES_W-1:0];
        REG_ROW_COUNT:     cfg.row_count <= cfg_data[ROWS_W-1:0];
        REG_TICK_OVERHEAD: cfg.tick_overhead <= cfg_data[OVH_W-1:0];
        REG_ROW_LENGTH:    cfg.row_length <= cfg_data[ROWLEN_W-1:0];
        default: ;
      endcase
    end
  end

  bcmscan_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_PLANES(MAX_PLANES),
    .EW(EW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .qstat(qstat),
    .tick(tick),
    .push(push),
    .entry(entry)
  );

  bcmscan_fifo #(
    .W(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata(entry),
    .pop(q_take),
    .rdata(q_data),
    .qstat(qstat)
  );

  bcmscan_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_PLANES(MAX_PLANES),
    .EW(EW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(!qstat.empty),
    .q_data(q_data),
    .q_take(q_take),
    .result(result)
  );

  a_reset_no_result: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(qstat.empty && qstat.full))
    else $error("queue reports empty and full at once");

  // select lines move only on the tick that enters plane 1, or every tick with one plane
  a_mux_plane: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.mux_update && result.plane_index != PLANEIDX_W'(1)
      |-> result.plane_index == '0)
    else $error("row select update on an unexpected plane");

endmodule
